// File: design/pqws_pkg.sv
// ----------------------------------------------------------------------------
// pqws_pkg: shared types and constants for the priority queue with wait stats
// Item and result structs, cell control struct, opcodes, status codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package pqws_pkg;

    localparam int DEPTH           = 16;
    localparam int PRIORITY_LEVELS = 8;
    localparam int CNT_W           = $clog2(DEPTH + 1);

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_PRIORITY_MODE = 8'd0;
    localparam logic [7:0] CFG_HISTORY_LIMIT = 8'd1;

    localparam logic [15:0] HISTORY_LIMIT_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] patient_id;
        logic [2:0]  patient_priority;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] removed_id;
        logic        found;
        logic [4:0]  queue_size;
        logic        head_valid;
        logic [15:0] head_id;
        logic [47:0] total_wait;
        logic [31:0] served_count;
        logic [39:0] size_sum;
        logic [15:0] samples_recorded;
    } t_result;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  pri;
        logic [31:0] tstamp;
    } t_entry;

    // broadcast to every cell of the row
    typedef struct packed {
        logic        cmp;      // compare phase: latch insert-point flag
        logic        ins;      // update phase: open a slot and shift right
        logic        rem;      // update phase: shift left over the head
        logic        mode;     // priority ordering enabled
        logic [15:0] key_id;
        logic [2:0]  key_pri;
    } t_cell_ctrl;

endpackage

// File: design/pqws_cell.sv
// ----------------------------------------------------------------------------
// pqws_cell: one slot of the shift-register queue
// Holds one entry, flags whether an insert lands here, and moves data to or
// from its neighbors on insert and removal.
// ----------------------------------------------------------------------------
module pqws_cell
    import pqws_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  logic       i_at_tail,
    input  logic       i_ge_left,
    input  t_entry     i_new,
    input  t_entry     i_left,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_ge,
    output logic       o_match
);

    t_entry r_entry;
    logic   r_sel;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_sel <= i_at_tail |
                     (i_occupied & i_ctrl.mode & (i_ctrl.key_pri > r_entry.pri));
        end
        if (i_ctrl.ins) begin
            if (i_ge_left) begin
                r_entry <= i_left;
            end else if (r_sel) begin
                r_entry <= i_new;
            end
        end else if (i_ctrl.rem) begin
            r_entry <= i_right;
        end
    end

    // insert point lies at or left of this cell
    assign o_ge    = i_ge_left | r_sel;
    assign o_match = i_occupied & (r_entry.id == i_ctrl.key_id);
    assign o_entry = r_entry;

endmodule

// File: design/pqws_chain.sv
// ----------------------------------------------------------------------------
// pqws_chain: row of queue cells
// Wires DEPTH cells neighbor to neighbor, derives occupancy per slot and
// collects the membership hits.
// ----------------------------------------------------------------------------
module pqws_chain
    import pqws_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [CNT_W-1:0] i_count,
    input  t_entry           i_new,
    output t_entry           o_head,
    output logic             o_found
);

    t_entry           ent   [DEPTH];
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] match;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left_ent;
        t_entry right_ent;
        logic   ge_left;

        if (g == 0) begin : g_first
            assign left_ent = i_new;
            assign ge_left  = 1'b0;
        end else begin : g_mid
            assign left_ent = ent[g-1];
            assign ge_left  = ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_ent = ent[g];
        end else begin : g_inner
            assign right_ent = ent[g+1];
        end

        pqws_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_occupied (CNT_W'(g) < i_count),
            .i_at_tail  (CNT_W'(g) == i_count),
            .i_ge_left  (ge_left),
            .i_new      (i_new),
            .i_left     (left_ent),
            .i_right    (right_ent),
            .o_entry    (ent[g]),
            .o_ge       (ge[g]),
            .o_match    (match[g])
        );
    end

    assign o_head  = ent[0];
    assign o_found = |match;

endmodule

// File: design/priority_queue_with_wait_stats.sv
// ----------------------------------------------------------------------------
// priority_queue_with_wait_stats: stable priority queue with wait statistics
// An accepted item is compared on the accept edge and shifted on the update
//   edge, which also registers the result strobe. No new item is taken while busy,
//   which is high for the single update cycle between the compare edge and the shift edge
//   of the cell row. The receiver cannot stall: o_done lasts one cycle.
// Reset (synchronous, active low): queue empty, statistics zero, FIFO mode,
//   history limit 1000. Entry slots are not cleared; none is read unwritten.
// ----------------------------------------------------------------------------
module priority_queue_with_wait_stats
    import pqws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    // result strobe
    output logic        o_done,
    output t_result     o_result,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // two-phase sequencer
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic r_state, n_state;
    logic r_done;

    // configuration
    logic        r_priority_mode;
    logic [15:0] r_history_limit;

    // item latched at accept
    logic [1:0]  r_op;
    t_entry      r_new;
    logic [31:0] r_wait;       // head wait, precomputed at accept
    logic        r_found;

    // queue state and statistics
    logic [CNT_W-1:0] r_count, n_count;
    logic [47:0]      r_total_wait, n_total_wait;
    logic [31:0]      r_served, n_served;
    logic [39:0]      r_size_sum, n_size_sum;
    logic [15:0]      r_samples, n_samples;

    // result fields latched on update
    logic [1:0]  r_status, n_status;
    logic [15:0] r_removed, n_removed;

    logic        accept;
    logic        cfg_we;
    logic        full, empty;
    logic [2:0]  key_pri;
    t_cell_ctrl  ctrl;
    t_entry      head;
    logic        chain_found;

    logic        take_sample;
    logic [48:0] wait_sum;
    logic [40:0] size_add;

    assign accept      = start & ~busy;
    assign busy        = (r_state == ST_UPD);
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // out-of-range priorities fold onto the top level
    assign key_pri = (32'(i_cmd.patient_priority) >= PRIORITY_LEVELS) ?
                     3'(PRIORITY_LEVELS - 1) : i_cmd.patient_priority;

    // compare on the accept edge, shift on the update edge
    always_comb begin
        ctrl.cmp     = accept;
        ctrl.ins     = busy & (r_op == OP_INSERT) & ~full;
        ctrl.rem     = busy & (r_op == OP_REMOVE) & ~empty;
        ctrl.mode    = r_priority_mode;
        ctrl.key_id  = i_cmd.patient_id;
        ctrl.key_pri = key_pri;
    end

    pqws_chain u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_count (r_count),
        .i_new   (r_new),
        .o_head  (head),
        .o_found (chain_found)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // statistics and count for the update cycle
    always_comb begin
        n_count      = r_count;
        n_total_wait = r_total_wait;
        n_served     = r_served;
        n_size_sum   = r_size_sum;
        n_samples    = r_samples;
        n_status     = STAT_OK;
        n_removed    = '0;
        take_sample  = 1'b0;

        wait_sum = 49'(r_total_wait) + 49'(r_wait);

        case (r_op)
            OP_INSERT: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_count     = r_count + 1'b1;
                    take_sample = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_count      = r_count - 1'b1;
                    n_removed    = head.id;
                    n_total_wait = wait_sum[48] ? '1 : wait_sum[47:0];
                    n_served     = (r_served == '1) ? r_served : r_served + 1'b1;
                    take_sample  = 1'b1;
                end
            end
            OP_TEST: begin
                // read only
            end
            OP_CLEAR: begin
                n_count      = '0;
                n_total_wait = '0;
                n_served     = '0;
                n_size_sum   = '0;
                n_samples    = '0;
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase

        // size sample uses the post-operation count
        size_add = 41'(r_size_sum) + 41'(n_count);
        if (take_sample && (r_samples < r_history_limit)) begin
            n_size_sum = size_add[40] ? '1 : size_add[39:0];
            n_samples  = r_samples + 1'b1;
        end
    end

    // control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_done          <= 1'b0;
            r_priority_mode <= 1'b0;
            r_history_limit <= HISTORY_LIMIT_RESET;
            r_count         <= '0;
            r_total_wait    <= '0;
            r_served        <= '0;
            r_size_sum      <= '0;
            r_samples       <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= busy;
            if (cfg_we) begin
                if (i_cfg_index == CFG_PRIORITY_MODE) begin
                    r_priority_mode <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_HISTORY_LIMIT) begin
                    r_history_limit <= i_cfg_data;
                end
            end
            if (busy) begin
                r_count      <= n_count;
                r_total_wait <= n_total_wait;
                r_served     <= n_served;
                r_size_sum   <= n_size_sum;
                r_samples    <= n_samples;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_cmd.op;
            r_new.id     <= i_cmd.patient_id;
            r_new.pri    <= key_pri;
            r_new.tstamp <= i_cmd.now;
            // entry stamped after now counts as zero wait
            r_wait       <= (i_cmd.now >= head.tstamp) ? i_cmd.now - head.tstamp : '0;
            r_found      <= chain_found & (i_cmd.op == OP_TEST);
        end
        if (busy) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    // queue state is stable during the strobe cycle, so read it directly
    assign o_done = r_done;
    always_comb begin
        o_result.status           = r_status;
        o_result.removed_id       = r_removed;
        o_result.found            = r_found;
        o_result.queue_size       = 5'(r_count);
        o_result.head_valid       = ~empty;
        o_result.head_id          = empty ? '0 : head.id;
        o_result.total_wait       = r_total_wait;
        o_result.served_count     = r_served;
        o_result.size_sum         = r_size_sum;
        o_result.samples_recorded = r_samples;
    end

    // ---------------------------------------------------------------- checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> $past(start && !busy))
        else $error("busy without a preceding accept");

    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an update cycle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STAT_FULL) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STAT_EMPTY) |-> !o_result.head_valid)
        else $error("empty status with a head entry");

endmodule

// File: verif/pqws_checker.sv
// ----------------------------------------------------------------------------
// pqws_checker: shadow model and result checker for the wait-stats queue
// Watches the command, result and register channels, keeps its own copy of
// the queue and statistics, and compares every result strobe field by field.
// ----------------------------------------------------------------------------
module pqws_checker
    import pqws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_cmd        i_cmd,
    input  logic        i_done,
    input  t_result     i_result,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int MAX_PRINTED = 100;

    // shadow queue, slot 0 is the head
    logic [15:0] slot_id   [DEPTH];
    logic [2:0]  slot_pri  [DEPTH];
    logic [31:0] slot_time [DEPTH];
    int          fill;

    logic [47:0] wait_sum;
    logic [31:0] served;
    logic [39:0] size_acc;
    logic [15:0] samples;

    logic        prio_mode;
    logic [15:0] hist_limit;

    t_result     awaited [$];

    task automatic report_mismatch(input string what);
        if (o_errors < MAX_PRINTED) begin
            $display("[%0t] ERROR: %s", $time, what);
        end
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d, %s: got %0h, expected %0h",
                                      o_checked, name, got, want));
        end
    endtask

    function automatic void sample_size();
        logic [40:0] acc;
        if (samples < hist_limit) begin
            acc = {1'b0, size_acc} + 41'(fill);
            size_acc = acc[40] ? '1 : acc[39:0];
            samples++;
        end
    endfunction

    // advance the shadow state by one command, return the result it causes
    function automatic t_result apply_command(input t_cmd c);
        t_result     r;
        logic [2:0]  pri;
        int          pos;
        logic [31:0] waited;
        logic [48:0] wsum;
        r   = '0;
        pri = (c.patient_priority >= PRIORITY_LEVELS) ? 3'(PRIORITY_LEVELS - 1)
                                                      : c.patient_priority;
        case (c.op)
            OP_INSERT: begin
                if (fill >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // first entry of strictly lower priority, else the tail
                    pos = fill;
                    if (prio_mode) begin
                        for (int i = fill - 1; i >= 0; i--) begin
                            if (pri > slot_pri[i]) pos = i;
                        end
                    end
                    for (int i = fill; i > pos; i--) begin
                        slot_id[i]   = slot_id[i-1];
                        slot_pri[i]  = slot_pri[i-1];
                        slot_time[i] = slot_time[i-1];
                    end
                    slot_id[pos]   = c.patient_id;
                    slot_pri[pos]  = pri;
                    slot_time[pos] = c.now;
                    fill++;
                    sample_size();
                end
            end
            OP_REMOVE: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    // entry stamped after now waits zero
                    waited = (c.now >= slot_time[0]) ? c.now - slot_time[0] : '0;
                    r.removed_id = slot_id[0];
                    for (int i = 1; i < fill; i++) begin
                        slot_id[i-1]   = slot_id[i];
                        slot_pri[i-1]  = slot_pri[i];
                        slot_time[i-1] = slot_time[i];
                    end
                    fill--;
                    wsum     = {1'b0, wait_sum} + 49'(waited);
                    wait_sum = wsum[48] ? '1 : wsum[47:0];
                    if (served != '1) served++;
                    sample_size();
                end
            end
            OP_TEST: begin
                for (int i = 0; i < fill; i++) begin
                    if (slot_id[i] == c.patient_id) r.found = 1'b1;
                end
            end
            default: begin
                fill     = 0;
                wait_sum = '0;
                served   = '0;
                size_acc = '0;
                samples  = '0;
            end
        endcase
        r.queue_size       = 5'(fill);
        r.head_valid       = (fill != 0);
        r.head_id          = (fill != 0) ? slot_id[0] : '0;
        r.total_wait       = wait_sum;
        r.served_count     = served;
        r.size_sum         = size_acc;
        r.samples_recorded = samples;
        return r;
    endfunction

    task automatic compare_result(input t_result want, input t_result got);
        check_field("status",       64'(got.status),       64'(want.status));
        check_field("removed_id",   64'(got.removed_id),   64'(want.removed_id));
        check_field("found",        64'(got.found),        64'(want.found));
        check_field("queue_size",   64'(got.queue_size),   64'(want.queue_size));
        check_field("head_valid",   64'(got.head_valid),   64'(want.head_valid));
        check_field("head_id",      64'(got.head_id),      64'(want.head_id));
        check_field("total_wait",   64'(got.total_wait),   64'(want.total_wait));
        check_field("served_count", 64'(got.served_count), 64'(want.served_count));
        check_field("size_sum",     64'(got.size_sum),     64'(want.size_sum));
        check_field("samples_recorded", 64'(got.samples_recorded),
                    64'(want.samples_recorded));
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill       = 0;
            wait_sum   = '0;
            served     = '0;
            size_acc   = '0;
            samples    = '0;
            prio_mode  = 1'b0;
            hist_limit = HISTORY_LIMIT_RESET;
            awaited.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRIORITY_MODE: prio_mode  = i_cfg_data[0];
                    CFG_HISTORY_LIMIT: hist_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done) begin
                if (awaited.size() == 0) begin
                    report_mismatch("result strobe with no item outstanding");
                end else begin
                    compare_result(awaited.pop_front(), i_result);
                end
            end
            if (i_start && !i_busy) begin
                awaited.push_back(apply_command(i_cmd));
            end
        end
        o_pending = awaited.size();
    end

endmodule

// File: verif/tb_priority_queue_with_wait_stats.sv
// ----------------------------------------------------------------------------
// tb_priority_queue_with_wait_stats: top of the wait-stats queue testbench
// Directed corner items, then random bursts that fill and drain the queue
// under several ordering modes and sample limits, with random sender gaps.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_priority_queue_with_wait_stats;
    import pqws_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE_CYCLES = 4;      // margin after the last result
    localparam int RUN_LIMIT = 2_000_000;  // time units, far beyond a clean run

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_cmd        i_cmd = '0;
    logic        o_done;
    t_result     o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int          mismatches;
    int          outstanding;
    int          compared;

    // stimulus bookkeeping for the summary
    int          op_count [4];
    int          reg_writes;
    logic [31:0] tick = '0;         // running time stamp for random items
    logic [15:0] id_pool [8];       // small id set so membership tests hit

    always #HALF_PERIOD i_clk = ~i_clk;

    priority_queue_with_wait_stats dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pqws_checker shadow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (i_cmd),
        .i_done      (o_done),
        .i_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (mismatches),
        .o_pending   (outstanding),
        .o_checked   (compared)
    );

    function automatic t_cmd make_item(input logic [1:0] op, input logic [15:0] id,
                                       input logic [2:0] pri, input logic [31:0] now);
        t_cmd c;
        c.op               = op;
        c.patient_id       = id;
        c.patient_priority = pri;
        c.now              = now;
        return c;
    endfunction

    // Random item. insert_pct steers a burst toward filling or draining;
    // clears are rare so the statistics get to grow.
    function automatic t_cmd random_item(input int unsigned insert_pct);
        t_cmd        c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            c.op = OP_CLEAR;
        end else if (roll < 2 + insert_pct) begin
            c.op = OP_INSERT;
        end else begin
            c.op = ($urandom_range(0, 2) == 2) ? OP_TEST : OP_REMOVE;
        end
        c.patient_id = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, 7)]
                                                   : 16'($urandom_range(0, 65535));
        c.patient_priority = 3'($urandom_range(0, 7));
        tick = tick + $urandom_range(0, 3000);
        // now and then a wild time stamp, so some waits go negative and clamp
        c.now = ($urandom_range(0, 99) < 6) ? 32'($urandom) : tick;
        return c;
    endfunction

    // Present one item from a falling edge and hold it until taken.
    // start stays high on return; the next call or a gap decides its level.
    task automatic send_item(input t_cmd c);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        op_count[c.op]++;
    endtask

    task automatic sender_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Hold off until every outstanding result is back, then let the
    // pipeline settle. Register writes only happen after this.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // One random phase: fixed register setting, bursts of insert-heavy,
    // balanced or remove-heavy items so the queue swings full and empty.
    task automatic run_phase(input logic mode, input logic [15:0] limit,
                             input int unsigned idle_pct, input int items);
        int          left_in_burst;
        int unsigned insert_pct;
        left_in_burst = 0;
        insert_pct    = 45;
        wait_drained();
        write_reg(CFG_PRIORITY_MODE, {15'd0, mode});
        write_reg(CFG_HISTORY_LIMIT, limit);
        for (int n = 0; n < items; n++) begin
            if (left_in_burst == 0) begin
                left_in_burst = $urandom_range(16, 40);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 20;
                    1:       insert_pct = 45;
                    default: insert_pct = 75;
                endcase
            end
            left_in_burst--;
            send_item(random_item(insert_pct));
            if ($urandom_range(0, 99) < idle_pct) begin
                sender_gap($urandom_range(1, 5));
            end
            // occasional full stop mid-phase
            if ($urandom_range(0, 149) == 0) wait_drained();
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom_range(0, 65535));
        id_pool[0] = '0;
        id_pool[1] = '1;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset defaults, FIFO order, history limit 1000 ---
        send_item(make_item(OP_REMOVE, 16'h0000, 3'd0, 32'd0));       // empty remove
        send_item(make_item(OP_INSERT, 16'hFFFF, 3'd7, 32'hFFFF_FFFF));
        send_item(make_item(OP_INSERT, 16'h0000, 3'd0, 32'd0));
        send_item(make_item(OP_TEST,   16'hFFFF, 3'd0, 32'd0));       // present
        send_item(make_item(OP_TEST,   16'h1234, 3'd0, 32'd0));       // absent
        // head was stamped after now: wait clamps to zero
        send_item(make_item(OP_REMOVE, 16'h0000, 3'd0, 32'd10));
        // fill to the top with mixed priorities in arrival order
        for (int i = 1; i < DEPTH; i++) begin
            send_item(make_item(OP_INSERT, 16'(i * 4099), 3'(i), 32'(i * 100)));
        end
        send_item(make_item(OP_INSERT, 16'hBEEF, 3'd3, 32'd5000));    // full insert
        wait_drained();

        // switch to priority order with unsorted entries still queued
        write_reg(CFG_PRIORITY_MODE, 16'd1);
        // head stamped at zero, now at max: the largest single wait
        send_item(make_item(OP_REMOVE, 16'h0000, 3'd0, 32'hFFFF_FFFF));
        send_item(make_item(OP_INSERT, 16'hA5A5, 3'd5, 32'd6000));
        send_item(make_item(OP_CLEAR,  16'h0000, 3'd0, 32'd0));
        tick = 32'd7000;

        // --- random phases: ordering, sample limit, sender idle share ---
        run_phase(1'b1, 16'd65535, 0,  200);
        run_phase(1'b0, 16'd0,     68, 180);
        run_phase(1'b1, 16'd3,     26, 180);
        run_phase(1'b0, 16'd65535, 26, 180);
        run_phase(1'b1, 16'd1000,  68, 200);
        run_phase(1'b1, 16'd0,     0,  100);
        run_phase(1'b0, 16'd7,     68, 110);
        wait_drained();

        $display("Run covered %0d inserts, %0d removals, %0d membership tests, %0d clears",
                 op_count[OP_INSERT], op_count[OP_REMOVE], op_count[OP_TEST],
                 op_count[OP_CLEAR]);
        $display("%0d results compared across %0d register writes, FIFO and priority order",
                 compared, reg_writes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog for a hung handshake or lost results
    initial begin
        #RUN_LIMIT;
        $display("Timed out with %0d results outstanding", outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
design/pqws_pkg.sv
design/pqws_cell.sv
design/pqws_chain.sv
design/priority_queue_with_wait_stats.sv
verif/pqws_checker.sv
verif/tb_priority_queue_with_wait_stats.sv
